// ===== src/residue_pair_edge_table_top_macros.svh =====
// Assertion macros for the residue pair edge table.
`ifndef RESIDUE_PAIR_EDGE_TABLE_TOP_MACROS_SVH
`define RESIDUE_PAIR_EDGE_TABLE_TOP_MACROS_SVH
`define RPET_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);
`define RPET_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);
`endif

// ===== src/rpet_pkg.sv =====
// Package: types, constants and state codes of the residue pair edge table.
package rpet_pkg;
	localparam int NUM_SEQS  = 16;
	localparam int NUM_RES   = 256;
	localparam int MAX_EDGES = 32;
	localparam int SEQ_W  = 4;
	localparam int RES_W  = 8;
	localparam int KEY_W  = SEQ_W + RES_W;
	localparam int SLOT_W = $clog2(NUM_SEQS) + $clog2(NUM_RES);
	localparam int POS_W  = $clog2(MAX_EDGES);
	localparam int LEN_W  = $clog2(MAX_EDGES + 1);
	localparam int ADDR_W = SLOT_W + POS_W;
	localparam int WGT_W  = 16;
	localparam int ENT_W  = KEY_W + WGT_W;

	localparam logic [1:0] ST_DONE  = 2'd0;
	localparam logic [1:0] ST_FULL  = 2'd1;
	localparam logic [1:0] ST_NOHIT = 2'd2;
	localparam logic       REQ_INSERT = 1'b0;
	localparam logic       REQ_UPDATE = 1'b1;

	typedef struct packed {
		logic       req_type;
		logic [3:0] seq_a;
		logic [7:0] res_a;
		logic [3:0] seq_b;
		logic [7:0] res_b;
		logic [15:0] edge_weight;
	} req_t;

	typedef struct packed {
		logic [1:0] status;
		logic [5:0] len_a;
		logic [5:0] len_b;
	} rsp_t;

	typedef enum logic [3:0] {
		S_CLR, S_IDLE, S_RDA, S_RDB, S_CHK, S_IRD, S_ICMP, S_IWR,
		S_URD, S_UCMP, S_FIN
	} state_t;
endpackage

// ===== src/residue_pair_edge_table_top.sv =====
// Top level: sorted per-residue edge lists held in two synchronous memories.
// One request in at a time: start is taken while busy is low, and the result
// appears on rsp for one cycle with done high; the receiver cannot stall it.
// After reset the block stays busy while it clears the length memory. A
// request then holds busy through the setup states S_RDA, S_RDB and S_CHK,
// the list work and the closing state S_FIN, and done rises in the same cycle
// that busy falls. An insert walks each list from its end, shifting every
// entry with a larger or equal key up by one, and stops on a smaller key or
// at the head, then writes the new entry; a full insert skips the list work.
// An update scans every entry of both lists and rewrites each match. The
// edge memory is single-port. A request naming a slot out of range goes from
// S_RDA straight to S_FIN.
module residue_pair_edge_table_top (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	output logic busy,
	input  rpet_pkg::req_t req,
	output logic done,
	output rpet_pkg::rsp_t rsp
);
	import rpet_pkg::*;
	`include "residue_pair_edge_table_top_macros.svh"

	localparam int NSLOT = NUM_SEQS * NUM_RES;
	localparam int NENT  = NSLOT * MAX_EDGES;

	logic [ENT_W-1:0] edge_mem [NENT];
	logic [LEN_W-1:0] len_mem  [NSLOT];

	state_t state_q, state_d;
	req_t   req_q;
	logic   side_q;
	logic [LEN_W-1:0] pos_q, la_q, lb_q;
	logic   hit_q;
	logic [1:0] stat_q;
	logic [ENT_W-1:0] erd_q;
	logic [LEN_W-1:0] lrd_q;
	logic   done_q;
	rsp_t   rsp_q;
	logic [SLOT_W-1:0] clr_q;

	logic [SLOT_W-1:0] slot_a, slot_b, cur_slot;
	logic [KEY_W-1:0]  key_a, key_b, cur_key, erd_key;
	logic [LEN_W-1:0]  cur_len;
	logic              in_range, same, room;

	logic e_we, l_we, l_re;
	logic [ADDR_W-1:0] e_addr;
	logic [ENT_W-1:0]  e_wd;
	logic [SLOT_W-1:0] l_addr;
	logic [LEN_W-1:0]  l_wd;

	assign in_range = (32'(req_q.seq_a) < NUM_SEQS) && (32'(req_q.seq_b) < NUM_SEQS)
		&& (32'(req_q.res_a) < NUM_RES) && (32'(req_q.res_b) < NUM_RES);
	assign slot_a = SLOT_W'({req_q.seq_a, req_q.res_a});
	assign slot_b = SLOT_W'({req_q.seq_b, req_q.res_b});
	assign key_a  = {req_q.seq_a, req_q.res_a};
	assign key_b  = {req_q.seq_b, req_q.res_b};
	assign same   = slot_a == slot_b;
	assign cur_slot = side_q ? slot_b : slot_a;
	assign cur_key  = side_q ? key_a : key_b;
	assign cur_len  = side_q ? lb_q : la_q;
	assign erd_key  = erd_q[ENT_W-1:WGT_W];
	assign room = same ? (32'(la_q) + 2 <= MAX_EDGES)
		: (32'(la_q) < MAX_EDGES && 32'(lrd_q) < MAX_EDGES);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_CLR:    if (clr_q == '1) state_d = S_IDLE;
			S_IDLE:   if (start) state_d = S_RDA;
			S_RDA:    state_d = in_range ? S_RDB : S_FIN;
			S_RDB:    state_d = S_CHK;
			S_CHK:    if (req_q.req_type == REQ_UPDATE) state_d = S_URD;
				else state_d = room ? S_IRD : S_FIN;
			S_IRD:    state_d = (pos_q == '0) ? S_IWR : S_ICMP;
			S_ICMP:   state_d = (erd_key < cur_key) ? S_IWR : S_IRD;
			S_IWR:    state_d = side_q ? S_FIN : S_IRD;
			S_URD:    state_d = (pos_q != cur_len) ? S_UCMP : (side_q ? S_FIN : S_URD);
			S_UCMP:   state_d = S_URD;
			S_FIN:    state_d = S_IDLE;
			default:  state_d = S_IDLE;
		endcase
	end

	always_comb begin
		e_we = 1'b0; l_we = 1'b0; l_re = 1'b0;
		e_addr = {cur_slot, pos_q[POS_W-1:0]};
		e_wd = {cur_key, req_q.edge_weight};
		l_addr = cur_slot; l_wd = cur_len + LEN_W'(1);
		unique case (state_q)
			S_CLR:    begin l_we = 1'b1; l_addr = clr_q; l_wd = '0; end
			S_RDA:    begin l_re = in_range; l_addr = slot_a; end
			S_RDB:    begin l_re = 1'b1; l_addr = slot_b; end
			S_IRD:    e_addr = {cur_slot, POS_W'(pos_q - LEN_W'(1))};
			S_ICMP:   if (!(erd_key < cur_key)) begin
				e_we = 1'b1;
				e_wd = erd_q;
			end
			S_IWR:    begin e_we = 1'b1; l_we = 1'b1; end
			S_UCMP:   e_we = erd_key == cur_key;
			default:  ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (e_we) edge_mem[e_addr] <= e_wd;
		erd_q <= edge_mem[e_addr];
		if (l_we) len_mem[l_addr] <= l_wd;
		if (l_re) lrd_q <= len_mem[l_addr];
		if (start && !busy) req_q <= req;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLR; clr_q <= '0; side_q <= 1'b0; pos_q <= '0;
			la_q <= '0; lb_q <= '0; hit_q <= 1'b0; stat_q <= ST_DONE;
			done_q <= 1'b0; rsp_q <= '0;
		end else begin
			state_q <= state_d;
			done_q <= state_q == S_FIN;
			unique case (state_q)
				S_CLR:  clr_q <= clr_q + SLOT_W'(1);
				S_IDLE: begin side_q <= 1'b0; hit_q <= 1'b0; stat_q <= ST_DONE; end
				S_RDB:  la_q <= lrd_q;
				S_CHK:  begin
					lb_q <= lrd_q;
					pos_q <= (req_q.req_type == REQ_UPDATE) ? '0 : la_q;
					if (req_q.req_type == REQ_INSERT && !room) stat_q <= ST_FULL;
				end
				S_ICMP: if (!(erd_key < cur_key)) pos_q <= pos_q - LEN_W'(1);
				S_IWR:  begin
					if (!side_q) begin
						la_q <= la_q + LEN_W'(1);
						if (same) lb_q <= lb_q + LEN_W'(1);
						pos_q <= same ? la_q + LEN_W'(1) : lb_q;
						side_q <= 1'b1;
					end else begin
						lb_q <= lb_q + LEN_W'(1);
						if (same) la_q <= la_q + LEN_W'(1);
					end
				end
				S_URD:  if (pos_q == cur_len && !side_q) begin
					side_q <= 1'b1;
					pos_q <= '0;
				end
				S_UCMP: begin
					if (erd_key == cur_key) hit_q <= 1'b1;
					pos_q <= pos_q + LEN_W'(1);
				end
				S_FIN:  begin
					if (!in_range) begin
						rsp_q.status <= (req_q.req_type == REQ_UPDATE) ? ST_NOHIT : ST_FULL;
						rsp_q.len_a <= '0;
						rsp_q.len_b <= '0;
					end else begin
						if (req_q.req_type == REQ_UPDATE)
							rsp_q.status <= hit_q ? ST_DONE : ST_NOHIT;
						else
							rsp_q.status <= stat_q;
						rsp_q.len_a <= la_q;
						rsp_q.len_b <= lb_q;
					end
				end
				default: ;
			endcase
		end
	end

	assign busy = state_q != S_IDLE;
	assign done = done_q;
	assign rsp  = rsp_q;

	`RPET_ASSERT_NEXT(a_done_pulse, clk, arst_n, done, !done, "done held two cycles")
	`RPET_ASSERT_IMPL(a_done_idle, clk, arst_n, done, !busy, "result while busy")
	`RPET_ASSERT_IMPL(a_len_range, clk, arst_n, busy, 32'(la_q) <= MAX_EDGES, "length overflow")
	`RPET_ASSERT_NEXT(a_start_busy, clk, arst_n, start && !busy, busy, "start not taken")
endmodule

// ===== tb/tb.sv =====
// Testbench for the residue pair edge table: queued random and directed requests, predicted results.
module tb;
	timeunit 1ns;
	timeprecision 1ps;
	import rpet_pkg::*;

	localparam int TIMEOUT_CYCLES = 2000000;
	localparam int SLOT_COUNT = NUM_SEQS * NUM_RES;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	req_t req = '0;
	logic done;
	rsp_t rsp;

	residue_pair_edge_table_top dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.req(req), .done(done), .rsp(rsp)
	);

	always #10 clk = ~clk;

	logic [ENT_W-1:0] edge_mem [SLOT_COUNT*MAX_EDGES];
	int unsigned edge_count [SLOT_COUNT];

	req_t pending_reqs[$];
	rsp_t expected_rsps[$];
	int unsigned sent_count = 0;
	int unsigned error_count = 0;
	int unsigned cycle_count = 0;

	function automatic void add_edge(int unsigned slot, logic [KEY_W-1:0] key,
			logic [WGT_W-1:0] w);
		int unsigned base;
		int unsigned pos;
		base = slot * MAX_EDGES;
		pos = edge_count[slot];
		while (pos > 0) begin
			if (edge_mem[base+pos-1][ENT_W-1:WGT_W] < key)
				break;
			edge_mem[base+pos] = edge_mem[base+pos-1];
			pos--;
		end
		edge_mem[base+pos] = {key, w};
		edge_count[slot]++;
	endfunction

	function automatic int unsigned set_weight(int unsigned slot, logic [KEY_W-1:0] key,
			logic [WGT_W-1:0] w);
		int unsigned base;
		int unsigned hits;
		base = slot * MAX_EDGES;
		hits = 0;
		for (int unsigned i = 0; i < edge_count[slot]; i++) begin
			if (edge_mem[base+i][ENT_W-1:WGT_W] == key) begin
				edge_mem[base+i] = {key, w};
				hits++;
			end
		end
		return hits;
	endfunction

	function automatic rsp_t apply_request(req_t r);
		rsp_t o;
		int unsigned sa;
		int unsigned sb;
		logic [KEY_W-1:0] ka;
		logic [KEY_W-1:0] kb;
		bit room;
		int unsigned hits;
		o = '0;
		ka = {r.seq_a, r.res_a};
		kb = {r.seq_b, r.res_b};
		if (r.seq_a >= NUM_SEQS || r.seq_b >= NUM_SEQS || r.res_a >= NUM_RES
				|| r.res_b >= NUM_RES) begin
			o.status = (r.req_type == REQ_UPDATE) ? ST_NOHIT : ST_FULL;
			return o;
		end
		sa = r.seq_a * NUM_RES + r.res_a;
		sb = r.seq_b * NUM_RES + r.res_b;
		o.status = ST_DONE;
		if (r.req_type == REQ_INSERT) begin
			if (sa == sb)
				room = edge_count[sa] + 2 <= MAX_EDGES;
			else
				room = edge_count[sa] < MAX_EDGES && edge_count[sb] < MAX_EDGES;
			if (room) begin
				add_edge(sa, kb, r.edge_weight);
				add_edge(sb, ka, r.edge_weight);
			end else begin
				o.status = ST_FULL;
			end
		end else begin
			hits = set_weight(sa, kb, r.edge_weight);
			hits += set_weight(sb, ka, r.edge_weight);
			if (hits == 0)
				o.status = ST_NOHIT;
		end
		o.len_a = edge_count[sa][5:0];
		o.len_b = edge_count[sb][5:0];
		return o;
	endfunction

	// driver: advance on transfer, idle at random outside the back-to-back stretch
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start <= 1'b0;
			req <= '0;
		end else if (!start || !busy) begin
			if (start) begin
				expected_rsps.insert(expected_rsps.size(), apply_request(req));
				sent_count++;
			end
			if (pending_reqs.size() > 0 && ((sent_count >= 700 && sent_count < 900)
					|| $urandom_range(99) >= 37)) begin
				start <= 1'b1;
				req <= pending_reqs.pop_front();
			end else begin
				start <= 1'b0;
			end
		end
	end

	// monitor
	always @(posedge clk) begin
		if (arst_n && done) begin
			if (expected_rsps.size() == 0) begin
				$error("unexpected result: status %0d len_a %0d len_b %0d",
					rsp.status, rsp.len_a, rsp.len_b);
				error_count++;
			end else begin
				rsp_t e;
				e = expected_rsps.pop_front();
				if (rsp.status !== e.status) begin
					$error("status: expected %0d, actual %0d", e.status, rsp.status);
					error_count++;
				end
				if (rsp.len_a !== e.len_a) begin
					$error("len_a: expected %0d, actual %0d", e.len_a, rsp.len_a);
					error_count++;
				end
				if (rsp.len_b !== e.len_b) begin
					$error("len_b: expected %0d, actual %0d", e.len_b, rsp.len_b);
					error_count++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > TIMEOUT_CYCLES) begin
			$display("tb: done, errors");
			$finish;
		end
	end

	function automatic req_t make_req(logic t, logic [3:0] sa, logic [7:0] ra,
			logic [3:0] sb, logic [7:0] rb, logic [15:0] w);
		req_t r;
		r.req_type = t;
		r.seq_a = sa;
		r.res_a = ra;
		r.seq_b = sb;
		r.res_b = rb;
		r.edge_weight = w;
		return r;
	endfunction

	function automatic void queue_req(req_t r);
		pending_reqs.insert(pending_reqs.size(), r);
	endfunction

	initial begin
		logic [11:0] pool [4];
		req_t history[$];
		req_t r;
		for (int i = 0; i < SLOT_COUNT; i++)
			edge_count[i] = 0;

		// directed: extremes, self pair, duplicate keys, updates with and without match
		queue_req(make_req(REQ_INSERT, 4'd0, 8'd0, 4'd15, 8'd255, 16'hFFFF));
		queue_req(make_req(REQ_INSERT, 4'd15, 8'd255, 4'd0, 8'd0, 16'h0000));
		queue_req(make_req(REQ_INSERT, 4'd0, 8'd0, 4'd0, 8'd0, 16'h5A5A));
		queue_req(make_req(REQ_INSERT, 4'd0, 8'd0, 4'd7, 8'd128, 16'hA5A5));
		queue_req(make_req(REQ_INSERT, 4'd0, 8'd0, 4'd0, 8'd255, 16'h1234));
		queue_req(make_req(REQ_UPDATE, 4'd0, 8'd0, 4'd15, 8'd255, 16'h8001));
		queue_req(make_req(REQ_UPDATE, 4'd15, 8'd255, 4'd0, 8'd0, 16'h7FFE));
		queue_req(make_req(REQ_UPDATE, 4'd0, 8'd0, 4'd0, 8'd0, 16'hFFFF));
		queue_req(make_req(REQ_UPDATE, 4'd3, 8'd3, 4'd9, 8'd9, 16'h0000));
		queue_req(make_req(REQ_UPDATE, 4'd15, 8'd255, 4'd15, 8'd255, 16'h0F0F));
		queue_req(make_req(REQ_INSERT, 4'd15, 8'd255, 4'd15, 8'd255, 16'hF0F0));
		queue_req(make_req(REQ_INSERT, 4'd8, 8'd1, 4'd7, 8'd254, 16'h00FF));

		// random: mostly requests among a few slots so lists fill up and overflow
		for (int n = 0; n < 1450; n++) begin
			if (n % 200 == 0)
				foreach (pool[i])
					pool[i] = 12'($urandom);
			if ($urandom_range(99) < 80) begin
				r.req_type = ($urandom_range(99) < 70) ? REQ_INSERT : REQ_UPDATE;
				{r.seq_a, r.res_a} = pool[$urandom_range(3)];
				{r.seq_b, r.res_b} = pool[$urandom_range(3)];
				r.edge_weight = 16'($urandom);
				if (r.req_type == REQ_UPDATE && history.size() > 0
						&& $urandom_range(99) < 70) begin
					r = history[$urandom_range(history.size() - 1)];
					r.req_type = REQ_UPDATE;
					r.edge_weight = 16'($urandom);
				end
			end else begin
				r = req_t'({$urandom, $urandom});
			end
			if (r.req_type == REQ_INSERT) begin
				history.insert(history.size(), r);
				if (history.size() > 64)
					void'(history.pop_front());
			end
			queue_req(r);
		end

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		while (pending_reqs.size() > 0 || start || expected_rsps.size() > 0)
			@(posedge clk);
		repeat (300) @(posedge clk);
		if (expected_rsps.size() > 0) begin
			$error("results still expected: %0d", expected_rsps.size());
			error_count++;
		end
		if (error_count == 0) begin
			$display("tb: done, clean");
		end else begin
			$display("tb: done, errors");
		end
		$finish;
	end
endmodule

// ===== residue_pair_edge_table_top.f =====
+incdir+src
src/rpet_pkg.sv
src/residue_pair_edge_table_top.sv
tb/tb.sv
